### rtl/core/tlbpt_pkg.sv
`timescale 1ns / 1ps
package tlbpt_pkg;
	localparam int TLB_ENTRIES    = 16;
	localparam int TLB_IDX_W      = $clog2(TLB_ENTRIES);
	localparam int PAGE_W         = 8;
	localparam int PAGE_COUNT     = 256;
	localparam int FRAME_W        = 8;
	localparam int FRAME_CAPACITY = 256;
	localparam int CNT_W          = 9;
	localparam int STAMP_W        = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_PICK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               hit;
		logic               fault;
		logic               evict;
		logic [PAGE_W-1:0]  victim;
	} result_t;
endpackage

### rtl/core/tlbpt_tlb.sv
`timescale 1ns / 1ps
// Fully associative TLB: FIFO fill and replacement, invalidation by tag.
module tlbpt_tlb (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tlbpt_pkg::PAGE_W-1:0]  lookup_page,
	output logic                         lookup_hit,
	output logic [tlbpt_pkg::FRAME_W-1:0] lookup_frame,
	input  logic                         install,
	input  logic [tlbpt_pkg::PAGE_W-1:0]  install_page,
	input  logic [tlbpt_pkg::FRAME_W-1:0] install_frame,
	input  logic                         inval,
	input  logic [tlbpt_pkg::PAGE_W-1:0]  inval_page
);
	logic [tlbpt_pkg::PAGE_W-1:0]  tag_q   [tlbpt_pkg::TLB_ENTRIES];
	logic [tlbpt_pkg::FRAME_W-1:0] frm_q   [tlbpt_pkg::TLB_ENTRIES];
	logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_q;
	logic [tlbpt_pkg::TLB_ENTRIES-1:0] valid_d;
	logic [tlbpt_pkg::TLB_IDX_W:0]   fill_q;
	logic [tlbpt_pkg::TLB_IDX_W-1:0] ptr_q;
	logic [tlbpt_pkg::TLB_IDX_W-1:0] slot;
	logic                            full;

	always_comb begin
		lookup_hit   = 1'b0;
		lookup_frame = '0;
		for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == lookup_page) begin
				lookup_hit   = 1'b1;
				lookup_frame = frm_q[i];
			end
		end
	end

	assign full = fill_q[tlbpt_pkg::TLB_IDX_W];
	assign slot = full ? ptr_q : fill_q[tlbpt_pkg::TLB_IDX_W-1:0];

	// invalidation first, then the new entry (victim and new page always differ)
	always_comb begin
		valid_d = valid_q;
		if (inval) begin
			for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
				if (tag_q[i] == inval_page) valid_d[i] = 1'b0;
			end
		end
		if (install) valid_d[slot] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			ptr_q   <= '0;
		end else begin
			valid_q <= valid_d;
			if (install) begin
				if (full) ptr_q <= ptr_q + 1'b1;
				else fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (install) begin
			tag_q[slot] <= install_page;
			frm_q[slot] <= install_frame;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		install |=> tag_q[$past(slot)] == $past(install_page))
		else $error("installed tag lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= tlbpt_pkg::TLB_ENTRIES) else $error("tlb fill overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		install |=> valid_q[$past(slot)]) else $error("installed slot not valid");
endmodule

### rtl/core/tlb_page_table_translator_top.sv
`timescale 1ns / 1ps
// Demand-paging address translator.
// Input stream (s_axis_*): one 16-bit logical address per transfer,
//   page in bits 15..8, offset in bits 7..0.
// Output stream (m_axis_*): one result per input transfer, tdata from
//   bit 0: physical_address[15:0], frame_number[7:0], tlb_hit, page_fault,
//   eviction, evicted_page[7:0], zero pad to 40 bits.
// Configuration: cfg_we/cfg_wdata write num_frames (9 bits, 0 acts as 1,
//   above 256 acts as 256). Write only while idle.
// A TLB hit, page-table hit or free-frame fault goes from the lookup state
//   straight to the output state (TLB compare and page-table read
//   resolve in the lookup cycle, write back at its end).
//   A fault that must evict scans every allocated frame stamp in the stamp
//   memory one per cycle before the pick state.
// One item is in flight at a time; s_axis_tready is low until the result
//   has been handed over. The result holds in the output register while
//   m_axis_tready is low.
// Reset: TLB and page residency cleared, frame counter and access clock
//   zero, num_frames 256. No clearing pass is needed: residency is kept in
//   flip-flops, the other tables are only read for written entries.
module tlb_page_table_translator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // logical_address[15:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // physical_address, frame_number, tlb_hit,
	                                   // page_fault, eviction, evicted_page
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);
	localparam int PW = tlbpt_pkg::PAGE_W;
	localparam int FW = tlbpt_pkg::FRAME_W;
	localparam int CW = tlbpt_pkg::CNT_W;
	localparam int SW = tlbpt_pkg::STAMP_W;

	tlbpt_pkg::state_t state_q, state_d;

	logic [CW-1:0] num_frames_q;
	logic [CW-1:0] alloc_q;
	logic [SW-1:0] clock_q;
	logic [PW-1:0] page_q;
	logic [7:0]    offset_q;

	// page table (frame map) and frame tables as memories
	logic [FW-1:0] pmap_mem  [tlbpt_pkg::PAGE_COUNT];
	logic [PW-1:0] owner_mem [tlbpt_pkg::FRAME_CAPACITY];
	logic [SW-1:0] stamp_mem [tlbpt_pkg::FRAME_CAPACITY];
	logic [tlbpt_pkg::PAGE_COUNT-1:0] resident_q;
	logic [tlbpt_pkg::PAGE_COUNT-1:0] resident_d;

	logic [FW-1:0] pmap_rd_q;
	logic [PW-1:0] owner_rd_q;
	logic [SW-1:0] stamp_rd_q;

	// scan registers
	logic [CW-1:0] scan_idx_q;   // address issued
	logic [FW-1:0] best_q;
	logic [SW-1:0] best_stamp_q;
	logic          scan_first_q;
	logic [FW-1:0] rd_idx_q;     // address of stamp_rd_q

	tlbpt_pkg::result_t res_q;

	logic          tlb_hit;
	logic [FW-1:0] tlb_frame;
	logic          install, inval;
	logic [FW-1:0] install_frame;
	logic [CW-1:0] limit;
	logic          can_alloc;
	logic [CW-1:0] scan_count;

	// control outputs
	logic          stamp_we;
	logic [FW-1:0] stamp_wa;
	logic          map_we;
	logic [FW-1:0] map_frame;
	logic          take_in, take_out;

	assign s_axis_tready = (state_q == tlbpt_pkg::ST_IDLE);
	assign take_in  = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == tlbpt_pkg::ST_OUT);
	assign take_out = m_axis_tvalid && m_axis_tready;

	assign limit = (num_frames_q == '0) ? CW'(1) : num_frames_q;
	assign can_alloc = (alloc_q < limit) && (alloc_q < CW'(tlbpt_pkg::FRAME_CAPACITY));
	assign scan_count = alloc_q;

	tlbpt_tlb u_tlb (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_page  (page_q),
		.lookup_hit   (tlb_hit),
		.lookup_frame (tlb_frame),
		.install      (install),
		.install_page (page_q),
		.install_frame(install_frame),
		.inval        (inval),
		.inval_page   (owner_rd_q)
	);

	always_comb begin
		state_d       = state_q;
		install       = 1'b0;
		inval         = 1'b0;
		install_frame = '0;
		stamp_we      = 1'b0;
		stamp_wa      = '0;
		map_we        = 1'b0;
		map_frame     = '0;
		case (state_q)
			tlbpt_pkg::ST_IDLE: begin
				if (take_in) state_d = tlbpt_pkg::ST_LOOK;
			end
			tlbpt_pkg::ST_LOOK: begin
				// pmap_rd_q is valid here (read issued on take_in)
				if (tlb_hit) begin
					stamp_we = 1'b1;
					stamp_wa = tlb_frame;
					state_d  = tlbpt_pkg::ST_OUT;
				end else if (resident_q[page_q]) begin
					stamp_we      = 1'b1;
					stamp_wa      = pmap_rd_q;
					install       = 1'b1;
					install_frame = pmap_rd_q;
					state_d       = tlbpt_pkg::ST_OUT;
				end else if (can_alloc) begin
					stamp_we      = 1'b1;
					stamp_wa      = alloc_q[FW-1:0];
					install       = 1'b1;
					install_frame = alloc_q[FW-1:0];
					map_we        = 1'b1;
					map_frame     = alloc_q[FW-1:0];
					state_d       = tlbpt_pkg::ST_OUT;
				end else begin
					state_d = tlbpt_pkg::ST_SCAN;
				end
			end
			tlbpt_pkg::ST_SCAN: begin
				if (scan_idx_q >= scan_count && !scan_first_q) state_d = tlbpt_pkg::ST_PICK;
			end
			tlbpt_pkg::ST_PICK: begin
				// owner_rd_q holds owner of best_q; victim entries drop as
				// the new page goes in
				inval         = 1'b1;
				install       = 1'b1;
				install_frame = best_q;
				stamp_we      = 1'b1;
				stamp_wa      = best_q;
				map_we        = 1'b1;
				map_frame     = best_q;
				state_d       = tlbpt_pkg::ST_OUT;
			end
			tlbpt_pkg::ST_OUT: begin
				if (take_out) state_d = tlbpt_pkg::ST_IDLE;
			end
			default: state_d = tlbpt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tlbpt_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// victim leaves, new page becomes resident
	always_comb begin
		resident_d = resident_q;
		if (inval) resident_d[owner_rd_q] = 1'b0;
		resident_d[page_q] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= CW'(256);
			alloc_q      <= '0;
			clock_q      <= '0;
			resident_q   <= '0;
			scan_idx_q   <= '0;
			scan_first_q <= 1'b0;
		end else begin
			if (cfg_we) num_frames_q <= cfg_wdata;
			if (take_in) clock_q <= clock_q + 1'b1;
			if (state_q == tlbpt_pkg::ST_LOOK && state_d == tlbpt_pkg::ST_OUT && map_we)
				alloc_q <= alloc_q + 1'b1;
			if (map_we) resident_q <= resident_d;
			if (state_q == tlbpt_pkg::ST_LOOK) begin
				scan_idx_q   <= CW'(1);
				scan_first_q <= 1'b1;
			end else if (state_q == tlbpt_pkg::ST_SCAN) begin
				scan_first_q <= 1'b0;
				if (scan_idx_q < scan_count) scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
	end

	// scan: stamp_rd_q holds stamp of rd_idx_q; compare in SCAN
	logic scan_rd_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_rd_valid_q <= 1'b0;
		else scan_rd_valid_q <= (state_q == tlbpt_pkg::ST_LOOK) ||
			(state_q == tlbpt_pkg::ST_SCAN && scan_idx_q < scan_count);
	end

	always_ff @(posedge clk) begin
		if (state_q == tlbpt_pkg::ST_SCAN && scan_rd_valid_q) begin
			if (scan_first_q || stamp_rd_q < best_stamp_q) begin
				best_q       <= rd_idx_q;
				best_stamp_q <= stamp_rd_q;
			end
		end
	end

	// memory ports
	logic [FW-1:0] stamp_ra;
	logic [FW-1:0] best_pick;
	always_comb begin
		stamp_ra = (state_q == tlbpt_pkg::ST_LOOK) ? '0 : scan_idx_q[FW-1:0];
		best_pick = best_q;
		if (scan_rd_valid_q && (stamp_rd_q < best_stamp_q || scan_first_q)) best_pick = rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			page_q   <= s_axis_tdata[15:8];
			offset_q <= s_axis_tdata[7:0];
		end
		pmap_rd_q  <= pmap_mem[take_in ? s_axis_tdata[15:8] : page_q];
		stamp_rd_q <= stamp_mem[stamp_ra];
		rd_idx_q   <= stamp_ra;
		owner_rd_q <= owner_mem[best_pick];
		if (stamp_we) stamp_mem[stamp_wa] <= clock_q;
		if (map_we) begin
			pmap_mem[page_q]     <= map_frame;
			owner_mem[map_frame] <= page_q;
		end
		if (state_q == tlbpt_pkg::ST_LOOK) begin
			res_q.hit    <= tlb_hit;
			res_q.fault  <= !tlb_hit && !resident_q[page_q];
			res_q.evict  <= 1'b0;
			res_q.victim <= '0;
			res_q.frame  <= tlb_hit ? tlb_frame :
				(resident_q[page_q] ? pmap_rd_q : alloc_q[FW-1:0]);
		end else if (state_q == tlbpt_pkg::ST_PICK) begin
			res_q.evict  <= 1'b1;
			res_q.victim <= owner_rd_q;
			res_q.frame  <= best_q;
		end
	end

	assign m_axis_tdata = {5'd0, res_q.victim, res_q.evict, res_q.fault, res_q.hit,
		res_q.frame, res_q.frame, offset_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> state_q == tlbpt_pkg::ST_LOOK) else $error("lookup not started");
	assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= CW'(tlbpt_pkg::FRAME_CAPACITY)) else $error("frame count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
endmodule
